FILE: rtl/core/shb_pkg.sv
// ----------------------------------------------------------------------------
// shb_pkg
// Shared types, constants and a helper function for the SHA-256 byte hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package shb_pkg;

    localparam int WORD_W   = 32;
    localparam int NUM_HASH = 8;
    localparam int NUM_SCHED = 16;
    localparam int NUM_ROUNDS = 64;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [2:0] LAST_WORD_IDX = 3'd7;
    localparam logic [63:0] BITS_PER_BYTE = 64'd8;

    typedef logic [NUM_HASH-1:0][WORD_W-1:0] hash_arr_t;

    localparam hash_arr_t INIT_HASH = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [WORD_W-1:0] ROUND_K [NUM_ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PAD   = 6'b000010,
        ST_LOAD  = 6'b000100,
        ST_ROUND = 6'b001000,
        ST_FOLD  = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    typedef struct packed {
        logic       shift_byte;
        logic [7:0] byte_in;
        logic       step;
    } sched_ctrl_t;

    typedef struct packed {
        logic init;
        logic load;
        logic step;
        logic fold;
    } round_ctrl_t;

    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] v,
                                               input int unsigned n);
        rotr = (v >> n) | (v << (WORD_W - n));
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/shb_sched.sv
// ----------------------------------------------------------------------------
// shb_sched
// Block buffer and message schedule window: collects bytes, then supplies
// one schedule word per round.
// ----------------------------------------------------------------------------
`default_nettype none

module shb_sched (
    input  logic                      aclk,
    input  shb_pkg::sched_ctrl_t      ctrl,
    output logic [shb_pkg::WORD_W-1:0] w_cur
);
    import shb_pkg::*;

    logic [WORD_W-1:0] w_reg  [NUM_SCHED];
    logic [WORD_W-1:0] w_next [NUM_SCHED];
    logic [WORD_W-1:0] s0;
    logic [WORD_W-1:0] s1;
    logic [WORD_W-1:0] w_new;

    always_comb begin
        s0    = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1    = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
    end

    always_comb begin
        for (int i = 0; i < NUM_SCHED; i++) begin
            w_next[i] = w_reg[i];
        end
        if (ctrl.shift_byte) begin
            for (int i = 0; i < NUM_SCHED - 1; i++) begin
                w_next[i] = {w_reg[i][WORD_W-9:0], w_reg[i+1][WORD_W-1:WORD_W-8]};
            end
            w_next[NUM_SCHED-1] = {w_reg[NUM_SCHED-1][WORD_W-9:0], ctrl.byte_in};
        end else if (ctrl.step) begin
            for (int i = 0; i < NUM_SCHED - 1; i++) begin
                w_next[i] = w_reg[i+1];
            end
            w_next[NUM_SCHED-1] = w_new;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_SCHED; i++) begin
            w_reg[i] <= w_next[i];
        end
    end

    assign w_cur = w_reg[0];

endmodule

`default_nettype wire

FILE: rtl/core/shb_round.sv
// ----------------------------------------------------------------------------
// shb_round
// Hash state and the shared compression round unit, one round per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module shb_round (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  shb_pkg::round_ctrl_t       ctrl,
    input  logic [shb_pkg::WORD_W-1:0] w_cur,
    input  logic [5:0]                 round_idx,
    output shb_pkg::hash_arr_t         hash
);
    import shb_pkg::*;

    hash_arr_t h_reg;
    hash_arr_t h_next;
    hash_arr_t v_reg;
    hash_arr_t v_next;

    logic [WORD_W-1:0] big0;
    logic [WORD_W-1:0] big1;
    logic [WORD_W-1:0] choose;
    logic [WORD_W-1:0] major;
    logic [WORD_W-1:0] t1;
    logic [WORD_W-1:0] t2;

    always_comb begin
        big1   = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        choose = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1     = v_reg[7] + big1 + choose + ROUND_K[round_idx] + w_cur;
        big0   = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        major  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2     = big0 + major;
    end

    always_comb begin
        v_next = v_reg;
        h_next = h_reg;
        if (ctrl.load) begin
            v_next = h_reg;
        end else if (ctrl.step) begin
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
        end
        if (ctrl.init) begin
            h_next = INIT_HASH;
        end else if (ctrl.fold) begin
            for (int i = 0; i < NUM_HASH; i++) begin
                h_next[i] = h_reg[i] + v_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_reg <= INIT_HASH;
        end else begin
            h_reg <= h_next;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg <= v_next;
    end

    assign hash = h_reg;

endmodule

`default_nettype wire

FILE: rtl/core/sha256_byte_hasher_core.sv
// ----------------------------------------------------------------------------
// sha256_byte_hasher_core
// SHA-256 over a byte stream with padding and digest readout.
// ----------------------------------------------------------------------------
// Input channel (s_*): one transfer per message byte. tdata carries the byte,
// tuser says whether the byte is present, tlast closes the message after it.
// A transfer with neither a byte nor tlast changes nothing.
// Output channel (m_*): eight transfers per message, digest word 0 first,
// tuser holds the word position and tlast marks word 7.
// A byte that does not complete a 64-byte block is taken while s_tready stays
// high. The byte that completes a block holds s_tready low through a load
// step, 64 rounds of the single round unit and a fold into the hash.
// At message end the pad bytes and length are shifted in one per cycle.
// The output stalls for as long as m_tready is low; the input stays closed
// until word 7 is taken, after which the hash returns to its initial value.
// Reset (aresetn low, synchronous) drops any partial message and leaves the
// block idle and ready.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_byte_hasher_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] byte_present
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast
);
    import shb_pkg::*;

    state_t      state_reg, state_next;
    logic [5:0]  count_reg, count_next;
    logic [5:0]  round_reg, round_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic [63:0] bits_reg, bits_next;
    logic        pad_active_reg, pad_active_next;
    logic        pad80_done_reg, pad80_done_next;
    logic        final_blk_reg, final_blk_next;

    sched_ctrl_t       sc;
    round_ctrl_t       rc;
    logic [WORD_W-1:0] w_cur;
    hash_arr_t         hash;

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        round_next      = round_reg;
        out_idx_next    = out_idx_reg;
        bits_next       = bits_reg;
        pad_active_next = pad_active_reg;
        pad80_done_next = pad80_done_reg;
        final_blk_next  = final_blk_reg;
        sc              = '0;
        rc              = '0;
        s_tready        = 1'b0;
        m_tvalid        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser) begin
                        sc.shift_byte = 1'b1;
                        sc.byte_in    = s_tdata;
                        count_next    = count_reg + 6'd1;
                        bits_next     = bits_reg + BITS_PER_BYTE;
                    end
                    if (s_tuser && count_reg == LAST_POS) begin
                        pad_active_next = s_tlast;
                        state_next      = ST_LOAD;
                    end else if (s_tlast) begin
                        pad_active_next = 1'b1;
                        state_next      = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                sc.shift_byte = 1'b1;
                if (!pad80_done_reg) begin
                    sc.byte_in      = PAD_BYTE;
                    pad80_done_next = 1'b1;
                    final_blk_next  = (count_reg < LEN_POS);
                end else if (final_blk_reg && count_reg >= LEN_POS) begin
                    sc.byte_in = bits_reg[63:56];
                    bits_next  = {bits_reg[55:0], 8'h00};
                end else begin
                    sc.byte_in = 8'h00;
                end
                count_next = count_reg + 6'd1;
                if (count_reg == LAST_POS) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                rc.load    = 1'b1;
                round_next = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                sc.step    = 1'b1;
                rc.step    = 1'b1;
                round_next = round_reg + 6'd1;
                if (round_reg == LAST_ROUND) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                rc.fold = 1'b1;
                if (pad_active_reg && final_blk_reg) begin
                    out_idx_next = '0;
                    state_next   = ST_OUT;
                end else if (pad_active_reg) begin
                    final_blk_next = pad80_done_reg;
                    state_next     = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (out_idx_reg == LAST_WORD_IDX) begin
                        rc.init         = 1'b1;
                        bits_next       = '0;
                        count_next      = '0;
                        pad_active_next = 1'b0;
                        pad80_done_next = 1'b0;
                        final_blk_next  = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            round_reg      <= '0;
            out_idx_reg    <= '0;
            bits_reg       <= '0;
            pad_active_reg <= 1'b0;
            pad80_done_reg <= 1'b0;
            final_blk_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            round_reg      <= round_next;
            out_idx_reg    <= out_idx_next;
            bits_reg       <= bits_next;
            pad_active_reg <= pad_active_next;
            pad80_done_reg <= pad80_done_next;
            final_blk_reg  <= final_blk_next;
        end
    end

    shb_sched u_sched (
        .aclk  (aclk),
        .ctrl  (sc),
        .w_cur (w_cur)
    );

    shb_round u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (rc),
        .w_cur     (w_cur),
        .round_idx (round_reg),
        .hash      (hash)
    );

    assign m_tdata = hash[out_idx_reg];
    assign m_tuser = out_idx_reg;
    assign m_tlast = (out_idx_reg == LAST_WORD_IDX);

endmodule

`default_nettype wire
